### design/dvrt_pkg.sv
`timescale 1ns / 1ps

package dvrt_pkg;

	localparam int MAX_NODES_DEF = 16;
	localparam int COST_BITS_DEF = 16;

	localparam int NODE_W     = 4;
	localparam int CMD_W      = 2;
	localparam int COST_W     = 16;
	localparam int DIST_OUT_W = 20;
	localparam int CNT_W      = 5;
	localparam int OUT_LIMIT  = 16;
	localparam int OUT_CNT_W  = $clog2(OUT_LIMIT + 1);
	localparam int RESET_COUNT_MAX = 16;

	typedef enum logic [CMD_W-1:0] {
		CMD_SET       = 2'd0,
		CMD_REMOVE    = 2'd1,
		CMD_RECOMPUTE = 2'd2,
		CMD_QUERY     = 2'd3
	} cmd_t;

	// controller -> datapath
	typedef struct packed {
		logic latch_cost;
		logic link_we;
		logic link_swap;
		logic link_clear;
		logic link_set;
		logic dist_ra_b;
		logic init_we;
		logic init_act;
		logic relax_we;
		logic cand_ld;
		logic par_ra_cur;
		logic par_we_a;
		logic par_we_old;
		logic old_ld;
		logic cur_ld_b;
		logic cur_ld_p;
		logic chain_push;
		logic k_clr;
		logic hop_wr;
		logic hop_sel_old;
		logic hop_ok;
		logic row_set;
		logic row_val;
		logic dist_ld;
		logic out_ld;
		logic out_reach;
		logic out_first;
		logic out_last;
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic cost_zero;
		logic link_present;
		logic da_inf;
		logic improve;
		logic tie;
		logic p_none;
		logic p_is_s;
		logic hop_gt;
		logic row_ok;
	} dp_status_t;

endpackage

### design/dvrt_dp.sv
`timescale 1ns / 1ps

module dvrt_dp #(
	parameter int MAX_NODES = dvrt_pkg::MAX_NODES_DEF,
	parameter int COST_BITS = dvrt_pkg::COST_BITS_DEF,
	parameter int NB        = $clog2(MAX_NODES),
	parameter int AW        = $clog2(MAX_NODES * MAX_NODES)
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  dvrt_pkg::dp_cmd_t                   cmd,
	output dvrt_pkg::dp_status_t                st,
	input  logic [NB-1:0]                       s_idx,
	input  logic [NB-1:0]                       a_idx,
	input  logic [NB-1:0]                       b_idx,
	input  logic [AW-1:0]                       clr_addr,
	input  logic [dvrt_pkg::OUT_CNT_W-1:0]      emit_idx,
	output logic [NB-1:0]                       k_cnt,
	input  logic [dvrt_pkg::COST_W-1:0]         edge_cost,
	output logic                                reachable,
	output logic [dvrt_pkg::DIST_OUT_W-1:0]     route_distance,
	output logic [dvrt_pkg::NODE_W-1:0]         next_hop,
	output logic [dvrt_pkg::NODE_W-1:0]         hop_node,
	output logic                                last_hop
);

	localparam int DEPTH = MAX_NODES * MAX_NODES;
	localparam int DW    = COST_BITS + NB;
	localparam int LW    = COST_BITS + 1;

	logic [LW-1:0]   link_mem [DEPTH];
	logic [DW:0]     dist_mem [DEPTH];
	logic [NB:0]     par_mem  [DEPTH];
	logic [NB-1:0]   chain_mem [MAX_NODES];

	logic [LW-1:0]   link_rd_q;
	logic [DW:0]     dist_rd_q;
	logic [NB:0]     par_rd_q;
	logic [NB-1:0]   chain_rd_q;

	logic [COST_BITS-1:0] cost_q;
	logic [DW-1:0]   cand_q;
	logic [DW-1:0]   dist_q;
	logic [NB:0]     old_q;
	logic [NB-1:0]   cur_q;
	logic [NB-1:0]   k_q;
	logic            hop_old_v_q, hop_new_v_q;
	logic [NB-1:0]   hop_old_q, hop_new_q;
	logic [MAX_NODES-1:0] row_valid_q;

	logic [AW-1:0]   link_wa, link_ra, dist_ra, par_ra, sb_addr;
	logic [LW-1:0]   link_wd;
	logic            dist_we, par_we, diag;
	logic [DW:0]     dist_wd;
	logic [NB:0]     par_wd;

	function automatic logic [AW-1:0] rc_addr(input logic [NB-1:0] r, input logic [NB-1:0] c);
		rc_addr = AW'(int'(r) * MAX_NODES + int'(c));
	endfunction

	always_comb begin
		sb_addr = rc_addr(s_idx, b_idx);
		link_ra = rc_addr(a_idx, b_idx);
		if (cmd.link_clear) begin
			link_wa = clr_addr;
			link_wd = '0;
		end else begin
			link_wa = cmd.link_swap ? rc_addr(b_idx, a_idx) : rc_addr(a_idx, b_idx);
			link_wd = cmd.link_set ? {1'b1, cost_q} : '0;
		end
		dist_ra = cmd.dist_ra_b ? sb_addr : rc_addr(s_idx, a_idx);
		par_ra  = cmd.par_ra_cur ? rc_addr(s_idx, cur_q) : sb_addr;

		diag    = cmd.init_act && (b_idx == s_idx);
		dist_we = cmd.init_we || cmd.relax_we;
		if (cmd.init_we)
			dist_wd = diag ? '0 : {1'b1, {DW{1'b0}}};
		else
			dist_wd = {1'b0, cand_q};

		par_we = cmd.init_we || cmd.relax_we || cmd.par_we_a || cmd.par_we_old;
		if (cmd.init_we)
			par_wd = diag ? {1'b0, s_idx} : {1'b1, {NB{1'b0}}};
		else if (cmd.par_we_old)
			par_wd = old_q;
		else
			par_wd = {1'b0, a_idx};
	end

	always_ff @(posedge clk) begin
		if (cmd.link_we || cmd.link_clear)
			link_mem[link_wa] <= link_wd;
		link_rd_q <= link_mem[link_ra];
	end

	always_ff @(posedge clk) begin
		if (dist_we)
			dist_mem[sb_addr] <= dist_wd;
		dist_rd_q <= dist_mem[dist_ra];
	end

	always_ff @(posedge clk) begin
		if (par_we)
			par_mem[sb_addr] <= par_wd;
		par_rd_q <= par_mem[par_ra];
	end

	always_ff @(posedge clk) begin
		if (cmd.chain_push)
			chain_mem[k_q] <= par_rd_q[NB-1:0];
		chain_rd_q <= chain_mem[NB'(int'(k_q) - int'(emit_idx))];
	end

	always_ff @(posedge clk) begin
		if (cmd.latch_cost)
			cost_q <= COST_BITS'(edge_cost);
		if (cmd.cand_ld)
			cand_q <= dist_rd_q[DW-1:0] + DW'(link_rd_q[COST_BITS-1:0]);
		if (cmd.dist_ld)
			dist_q <= dist_rd_q[DW-1:0];
		if (cmd.old_ld)
			old_q <= par_rd_q;
		if (cmd.cur_ld_b)
			cur_q <= b_idx;
		else if (cmd.cur_ld_p)
			cur_q <= par_rd_q[NB-1:0];
		if (cmd.k_clr)
			k_q <= '0;
		else if (cmd.chain_push)
			k_q <= k_q + 1'b1;
		if (cmd.hop_wr) begin
			if (cmd.hop_sel_old) begin
				hop_old_v_q <= cmd.hop_ok;
				hop_old_q   <= cur_q;
			end else begin
				hop_new_v_q <= cmd.hop_ok;
				hop_new_q   <= cur_q;
			end
		end
		if (cmd.out_ld) begin
			reachable      <= cmd.out_reach;
			route_distance <= cmd.out_reach ? dvrt_pkg::DIST_OUT_W'(dist_q) : '0;
			next_hop       <= cmd.out_reach ? dvrt_pkg::NODE_W'(hop_new_q) : '0;
			if (!cmd.out_reach)
				hop_node <= '0;
			else
				hop_node <= cmd.out_first ? dvrt_pkg::NODE_W'(s_idx)
					: dvrt_pkg::NODE_W'(chain_rd_q);
			last_hop       <= cmd.out_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
		end else if (cmd.row_set) begin
			row_valid_q[s_idx] <= cmd.row_val;
		end
	end

	always_comb begin
		st.cost_zero    = (COST_BITS'(edge_cost) == '0);
		st.link_present = link_rd_q[COST_BITS];
		st.da_inf       = dist_rd_q[DW];
		st.improve      = dist_rd_q[DW] || (cand_q < dist_rd_q[DW-1:0]);
		st.tie          = !dist_rd_q[DW] && (cand_q == dist_rd_q[DW-1:0]);
		st.p_none       = par_rd_q[NB];
		st.p_is_s       = !par_rd_q[NB] && (par_rd_q[NB-1:0] == s_idx);
		st.hop_gt       = hop_new_v_q && (!hop_old_v_q || (hop_new_q > hop_old_q));
		st.row_ok       = row_valid_q[s_idx];
	end

	assign k_cnt = k_q;

endmodule

### design/dvrt_ctrl.sv
`timescale 1ns / 1ps

module dvrt_ctrl #(
	parameter int MAX_NODES = dvrt_pkg::MAX_NODES_DEF,
	parameter int NB        = $clog2(MAX_NODES),
	parameter int AW        = $clog2(MAX_NODES * MAX_NODES)
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [dvrt_pkg::CMD_W-1:0]        command,
	input  logic [dvrt_pkg::NODE_W-1:0]       node_a,
	input  logic [dvrt_pkg::NODE_W-1:0]       node_b,
	input  logic [dvrt_pkg::CNT_W-1:0]        node_count,
	output logic                              out_valid,
	input  logic                              out_ready,
	output dvrt_pkg::dp_cmd_t                 cmd,
	input  dvrt_pkg::dp_status_t              st,
	output logic [NB-1:0]                     s_idx,
	output logic [NB-1:0]                     a_idx,
	output logic [NB-1:0]                     b_idx,
	output logic [AW-1:0]                     clr_addr,
	output logic [dvrt_pkg::OUT_CNT_W-1:0]    emit_idx,
	input  logic [NB-1:0]                     k_cnt
);

	localparam int SW = $clog2(MAX_NODES + 1);

	typedef enum logic [20:0] {
		ST_CLEAR    = 21'h000001,
		ST_IDLE     = 21'h000002,
		ST_LINK1    = 21'h000004,
		ST_LINK2    = 21'h000008,
		ST_ROWINIT  = 21'h000010,
		ST_RD_AB    = 21'h000020,
		ST_CHK_A    = 21'h000040,
		ST_CHK_B    = 21'h000080,
		ST_TIE_RD   = 21'h000100,
		ST_TIE_OLD  = 21'h000200,
		ST_WALK_RD  = 21'h000400,
		ST_WALK_CHK = 21'h000800,
		ST_TIE_SET  = 21'h001000,
		ST_TIE_CMP  = 21'h002000,
		ST_NEXT     = 21'h004000,
		ST_Q_RD     = 21'h008000,
		ST_Q_CHK    = 21'h010000,
		ST_Q_UNR    = 21'h020000,
		ST_E_RD     = 21'h040000,
		ST_E_OUT    = 21'h080000,
		ST_E_WAIT   = 21'h100000
	} state_t;

	typedef enum logic [1:0] {
		PH_OLD = 2'd0,
		PH_NEW = 2'd1,
		PH_QRY = 2'd2
	} phase_t;

	state_t state_q, state_d;
	phase_t phase_q, phase_d;
	dvrt_pkg::cmd_t cmd_q, cmd_d;
	logic [NB-1:0] s_q, s_d, a_q, a_d, b_q, b_d, r_q, r_d;
	logic [SW-1:0] steps_q, steps_d;
	logic [dvrt_pkg::OUT_CNT_W-1:0] i_q, i_d;
	logic [AW-1:0] clr_q, clr_d;
	logic last_q, last_d;

	logic in_a, in_b, act, walk_fail, emit_last;
	int   total;

	always_comb begin
		in_a = int'(node_a) < int'(node_count);
		in_b = int'(node_b) < int'(node_count);
		act  = int'(s_q) < int'(node_count);
		walk_fail = (phase_q == PH_QRY) ? (steps_q == SW'(MAX_NODES - 1))
			: (steps_q == SW'(MAX_NODES));
		total = int'(k_cnt) + 1;
		if (total > dvrt_pkg::OUT_LIMIT)
			total = dvrt_pkg::OUT_LIMIT;
		emit_last = (int'(i_q) + 1 >= total);
	end

	always_comb begin
		state_d = state_q;
		phase_d = phase_q;
		cmd_d   = cmd_q;
		s_d = s_q; a_d = a_q; b_d = b_q; r_d = r_q;
		steps_d = steps_q;
		i_d = i_q;
		clr_d = clr_q;
		last_d = last_q;
		cmd = '0;
		in_ready  = 1'b0;
		out_valid = 1'b0;

		unique case (state_q)
			ST_CLEAR: begin
				cmd.link_clear = 1'b1;
				clr_d = clr_q + 1'b1;
				if (clr_q == AW'(MAX_NODES * MAX_NODES - 1))
					state_d = ST_IDLE;
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.latch_cost = 1'b1;
					cmd_d = dvrt_pkg::cmd_t'(command);
					a_d = NB'(node_a);
					b_d = NB'(node_b);
					s_d = NB'(node_a);
					unique case (dvrt_pkg::cmd_t'(command))
						dvrt_pkg::CMD_SET, dvrt_pkg::CMD_REMOVE: begin
							if (in_a && in_b && (node_a != node_b)
								&& !((dvrt_pkg::cmd_t'(command) == dvrt_pkg::CMD_SET)
								&& st.cost_zero))
								state_d = ST_LINK1;
						end
						dvrt_pkg::CMD_RECOMPUTE: begin
							s_d = '0;
							b_d = '0;
							state_d = ST_ROWINIT;
						end
						default: begin
							state_d = (in_a && in_b) ? ST_Q_RD : ST_Q_UNR;
						end
					endcase
				end
			end
			ST_LINK1: begin
				cmd.link_we  = 1'b1;
				cmd.link_set = (cmd_q == dvrt_pkg::CMD_SET);
				state_d = ST_LINK2;
			end
			ST_LINK2: begin
				cmd.link_we   = 1'b1;
				cmd.link_swap = 1'b1;
				cmd.link_set  = (cmd_q == dvrt_pkg::CMD_SET);
				state_d = ST_IDLE;
			end
			ST_ROWINIT: begin
				cmd.init_we  = 1'b1;
				cmd.init_act = act;
				b_d = b_q + 1'b1;
				if (b_q == NB'(MAX_NODES - 1)) begin
					cmd.row_set = 1'b1;
					cmd.row_val = act;
					if (act && (int'(node_count) > 1)) begin
						a_d = '0;
						b_d = '0;
						r_d = '0;
						state_d = ST_RD_AB;
					end else if (s_q == NB'(MAX_NODES - 1)) begin
						state_d = ST_IDLE;
					end else begin
						s_d = s_q + 1'b1;
						b_d = '0;
					end
				end
			end
			ST_RD_AB: state_d = ST_CHK_A;
			ST_CHK_A: begin
				cmd.dist_ra_b = 1'b1;
				if (st.link_present && !st.da_inf) begin
					cmd.cand_ld = 1'b1;
					state_d = ST_CHK_B;
				end else begin
					state_d = ST_NEXT;
				end
			end
			ST_CHK_B: begin
				if (st.improve) begin
					cmd.relax_we = 1'b1;
					state_d = ST_NEXT;
				end else if (st.tie) begin
					state_d = ST_TIE_RD;
				end else begin
					state_d = ST_NEXT;
				end
			end
			ST_TIE_RD: state_d = ST_TIE_OLD;
			ST_TIE_OLD: begin
				cmd.old_ld   = 1'b1;
				cmd.cur_ld_b = 1'b1;
				steps_d = '0;
				phase_d = PH_OLD;
				state_d = ST_WALK_RD;
			end
			ST_WALK_RD: begin
				cmd.par_ra_cur = 1'b1;
				state_d = ST_WALK_CHK;
			end
			ST_WALK_CHK: begin
				cmd.hop_sel_old = (phase_q == PH_OLD);
				if (st.p_none || st.p_is_s || walk_fail) begin
					// chain resolved: record hop, or none when broken
					cmd.hop_wr = 1'b1;
					cmd.hop_ok = st.p_is_s;
					if (!st.p_none && !st.p_is_s) begin
						cmd.cur_ld_p   = 1'b1;
						cmd.chain_push = (phase_q == PH_QRY);
					end
					unique case (phase_q)
						PH_OLD: state_d = ST_TIE_SET;
						PH_NEW: state_d = ST_TIE_CMP;
						default: begin
							i_d = '0;
							state_d = st.p_is_s ? ST_E_RD : ST_Q_UNR;
						end
					endcase
				end else begin
					cmd.cur_ld_p   = 1'b1;
					cmd.chain_push = (phase_q == PH_QRY);
					steps_d = steps_q + 1'b1;
					state_d = ST_WALK_RD;
				end
			end
			ST_TIE_SET: begin
				cmd.par_we_a = 1'b1;
				cmd.cur_ld_b = 1'b1;
				steps_d = '0;
				phase_d = PH_NEW;
				state_d = ST_WALK_RD;
			end
			ST_TIE_CMP: begin
				cmd.par_we_old = st.hop_gt;
				state_d = ST_NEXT;
			end
			ST_NEXT: begin
				state_d = ST_RD_AB;
				if (int'(b_q) + 1 >= int'(node_count)) begin
					b_d = '0;
					if (int'(a_q) + 1 >= int'(node_count)) begin
						a_d = '0;
						if (int'(r_q) + 2 >= int'(node_count)) begin
							if (s_q == NB'(MAX_NODES - 1)) begin
								state_d = ST_IDLE;
							end else begin
								s_d = s_q + 1'b1;
								state_d = ST_ROWINIT;
							end
						end else begin
							r_d = r_q + 1'b1;
						end
					end else begin
						a_d = a_q + 1'b1;
					end
				end else begin
					b_d = b_q + 1'b1;
				end
			end
			ST_Q_RD: begin
				cmd.dist_ra_b = 1'b1;
				state_d = ST_Q_CHK;
			end
			ST_Q_CHK: begin
				if (!st.row_ok || st.da_inf) begin
					state_d = ST_Q_UNR;
				end else begin
					cmd.dist_ld  = 1'b1;
					cmd.cur_ld_b = 1'b1;
					cmd.k_clr    = 1'b1;
					steps_d = '0;
					phase_d = PH_QRY;
					state_d = ST_WALK_RD;
				end
			end
			ST_Q_UNR: begin
				cmd.out_ld   = 1'b1;
				cmd.out_last = 1'b1;
				last_d  = 1'b1;
				state_d = ST_E_WAIT;
			end
			ST_E_RD: state_d = ST_E_OUT;
			ST_E_OUT: begin
				cmd.out_ld    = 1'b1;
				cmd.out_reach = 1'b1;
				cmd.out_first = (i_q == '0);
				cmd.out_last  = emit_last;
				last_d  = emit_last;
				state_d = ST_E_WAIT;
			end
			ST_E_WAIT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					if (last_q) begin
						state_d = ST_IDLE;
					end else begin
						i_d = i_q + 1'b1;
						state_d = ST_E_RD;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			phase_q <= PH_OLD;
			cmd_q   <= dvrt_pkg::CMD_SET;
			s_q <= '0; a_q <= '0; b_q <= '0; r_q <= '0;
			steps_q <= '0;
			i_q <= '0;
			clr_q <= '0;
			last_q <= 1'b0;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
			cmd_q   <= cmd_d;
			s_q <= s_d; a_q <= a_d; b_q <= b_d; r_q <= r_d;
			steps_q <= steps_d;
			i_q <= i_d;
			clr_q <= clr_d;
			last_q <= last_d;
		end
	end

	assign s_idx    = s_q;
	assign a_idx    = a_q;
	assign b_idx    = b_q;
	assign clr_addr = clr_q;
	assign emit_idx = i_q;

endmodule

### design/distance_vector_route_table.sv
`timescale 1ns / 1ps

// Distance-vector route table. After reset the link memory is swept clear, one entry per
// cycle, before the first command is taken. Set and remove write both directions of the
// link unless the command is ignored. A query reads one parent per path edge, then emits
// its results one by one, each result held until taken. A recompute is a memory sequencer:
// per source it clears the row, then makes (n-1)*n*n link checks, and an equal-cost tie
// adds two parent-chain walks.
module distance_vector_route_table #(
	parameter int MAX_NODES = dvrt_pkg::MAX_NODES_DEF,
	parameter int COST_BITS = dvrt_pkg::COST_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [dvrt_pkg::CMD_W-1:0]         command,
	input  logic [dvrt_pkg::NODE_W-1:0]        node_a,
	input  logic [dvrt_pkg::NODE_W-1:0]        node_b,
	input  logic [dvrt_pkg::COST_W-1:0]        edge_cost,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic                               reachable,
	output logic [dvrt_pkg::DIST_OUT_W-1:0]    route_distance,
	output logic [dvrt_pkg::NODE_W-1:0]        next_hop,
	output logic [dvrt_pkg::NODE_W-1:0]        hop_node,
	output logic                               last_hop,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [2:0]                         paddr,
	input  logic [31:0]                        pwdata,
	output logic [31:0]                        prdata,
	output logic                               pready
);

	localparam int NB = $clog2(MAX_NODES);
	localparam int AW = $clog2(MAX_NODES * MAX_NODES);
	localparam int RESET_COUNT = (dvrt_pkg::RESET_COUNT_MAX > MAX_NODES) ? MAX_NODES
		: dvrt_pkg::RESET_COUNT_MAX;

	logic [dvrt_pkg::CNT_W-1:0] node_count_q;
	logic [dvrt_pkg::CNT_W-1:0] wr_val;

	dvrt_pkg::dp_cmd_t    cmd;
	dvrt_pkg::dp_status_t st;
	logic [NB-1:0] s_idx, a_idx, b_idx, k_cnt;
	logic [AW-1:0] clr_addr;
	logic [dvrt_pkg::OUT_CNT_W-1:0] emit_idx;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == 1'b0) ? 32'(node_count_q) : '0;

	always_comb begin
		wr_val = pwdata[dvrt_pkg::CNT_W-1:0];
		if (wr_val == '0)
			wr_val = dvrt_pkg::CNT_W'(1);
		else if (int'(wr_val) > MAX_NODES)
			wr_val = dvrt_pkg::CNT_W'(MAX_NODES);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= dvrt_pkg::CNT_W'(RESET_COUNT);
		end else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
			node_count_q <= wr_val;
		end
	end

	dvrt_ctrl #(
		.MAX_NODES(MAX_NODES),
		.NB(NB),
		.AW(AW)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.command(command),
		.node_a(node_a),
		.node_b(node_b),
		.node_count(node_count_q),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.cmd(cmd),
		.st(st),
		.s_idx(s_idx),
		.a_idx(a_idx),
		.b_idx(b_idx),
		.clr_addr(clr_addr),
		.emit_idx(emit_idx),
		.k_cnt(k_cnt)
	);

	dvrt_dp #(
		.MAX_NODES(MAX_NODES),
		.COST_BITS(COST_BITS),
		.NB(NB),
		.AW(AW)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.st(st),
		.s_idx(s_idx),
		.a_idx(a_idx),
		.b_idx(b_idx),
		.clr_addr(clr_addr),
		.emit_idx(emit_idx),
		.k_cnt(k_cnt),
		.edge_cost(edge_cost),
		.reachable(reachable),
		.route_distance(route_distance),
		.next_hop(next_hop),
		.hop_node(hop_node),
		.last_hop(last_hop)
	);

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

	localparam int NN = dvrt_pkg::MAX_NODES_DEF;
	localparam int unsigned INF = 32'hFFFF_FFFF;
	localparam logic [7:0] NO_PARENT = 8'hFF;
	localparam logic [2:0] REG_NODE_COUNT = 3'd0;

	typedef struct packed {
		logic        reach;
		logic [19:0] cost_sum;
		logic [3:0]  hop;
		logic [3:0]  node;
		logic        last;
	} route_hop_t;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_ready;
	logic [dvrt_pkg::CMD_W-1:0] command = '0;
	logic [dvrt_pkg::NODE_W-1:0] node_a = '0, node_b = '0;
	logic [dvrt_pkg::COST_W-1:0] edge_cost = '0;
	logic out_valid;
	logic out_ready = 0;
	logic reachable, last_hop;
	logic [dvrt_pkg::DIST_OUT_W-1:0] route_distance;
	logic [dvrt_pkg::NODE_W-1:0] next_hop, hop_node;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	distance_vector_route_table dut (.*);

	// local copy of the block state
	logic [16:0] link_mem [NN*NN];
	int unsigned dist_mem [NN*NN];
	logic [7:0] parent_mem [NN*NN];
	int unsigned active_nodes;

	route_hop_t route_q [$];
	int errors = 0;
	int hops_seen = 0;
	int queries_sent = 0;
	int recomputes_sent = 0;
	bit no_idle = 0;

	initial begin
		forever #1 clk = ~clk;
	end

	initial begin
		#8_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	function automatic int tree_first_hop(int s, int d);
		int cur;
		logic [7:0] p;
		cur = d;
		for (int st = 0; st <= NN; st++) begin
			p = parent_mem[s*NN + cur];
			if (p == NO_PARENT || p >= NN) return -1;
			if (p == s) return cur;
			cur = p;
		end
		return -1;
	endfunction

	function automatic void rebuild_row(int s);
		int unsigned w, da, db, cand;
		logic [7:0] old;
		int oh, nh;
		for (int a = 0; a < NN; a++) begin
			dist_mem[s*NN + a] = INF;
			parent_mem[s*NN + a] = NO_PARENT;
		end
		dist_mem[s*NN + s] = 0;
		parent_mem[s*NN + s] = s;
		for (int r = 1; r < active_nodes; r++)
			for (int a = 0; a < active_nodes; a++)
				for (int b = 0; b < active_nodes; b++) begin
					if (!link_mem[a*NN + b][16]) continue;
					da = dist_mem[s*NN + a];
					if (da == INF) continue;
					w = link_mem[a*NN + b][15:0];
					cand = da + w;
					db = dist_mem[s*NN + b];
					if (cand < db) begin
						dist_mem[s*NN + b] = cand;
						parent_mem[s*NN + b] = a;
					end else if (cand == db) begin
						old = parent_mem[s*NN + b];
						oh = tree_first_hop(s, b);
						parent_mem[s*NN + b] = a;
						nh = tree_first_hop(s, b);
						if (nh > oh) parent_mem[s*NN + b] = old;
					end
				end
	endfunction

	function automatic void queue_unreachable();
		route_hop_t h;
		h = '0;
		h.last = 1;
		route_q = {route_q, h};
	endfunction

	function automatic void predict_route(int s, int d);
		int chain [NN+1];
		int k, cur, hop, total;
		bit done;
		logic [7:0] p;
		route_hop_t h;
		k = 0;
		cur = d;
		done = 0;
		if (s >= active_nodes || d >= active_nodes || dist_mem[s*NN + d] == INF) begin
			queue_unreachable();
			return;
		end
		for (int st = 0; st < NN; st++) begin
			p = parent_mem[s*NN + cur];
			if (p == NO_PARENT || p >= NN) begin
				queue_unreachable();
				return;
			end
			if (p == s) begin
				done = 1;
				break;
			end
			chain[k++] = p;
			cur = p;
		end
		hop = tree_first_hop(s, d);
		if (!done || hop < 0) begin
			queue_unreachable();
			return;
		end
		total = (k + 1 > dvrt_pkg::OUT_LIMIT) ? dvrt_pkg::OUT_LIMIT : k + 1;
		for (int i = 0; i < total; i++) begin
			h.reach = 1;
			h.cost_sum = dist_mem[s*NN + d][19:0];
			h.hop = hop[3:0];
			h.node = (i == 0) ? s[3:0] : chain[k-i][3:0];
			h.last = (i + 1 == total);
			route_q = {route_q, h};
		end
	endfunction

	function automatic void apply_command(dvrt_pkg::cmd_t c, int a, int b, int cost);
		case (c)
			dvrt_pkg::CMD_SET: begin
				if (a < active_nodes && b < active_nodes && a != b && cost != 0) begin
					link_mem[a*NN + b] = {1'b1, cost[15:0]};
					link_mem[b*NN + a] = {1'b1, cost[15:0]};
				end
			end
			dvrt_pkg::CMD_REMOVE: begin
				if (a < active_nodes && b < active_nodes && a != b) begin
					link_mem[a*NN + b] = '0;
					link_mem[b*NN + a] = '0;
				end
			end
			dvrt_pkg::CMD_RECOMPUTE: begin
				for (int s = 0; s < NN; s++)
					if (s < active_nodes) rebuild_row(s);
					else for (int j = 0; j < NN; j++) begin
						dist_mem[s*NN + j] = INF;
						parent_mem[s*NN + j] = NO_PARENT;
					end
			end
			default: predict_route(a, b);
		endcase
	endfunction

	// called at a rising edge; returns at the accepting edge
	task automatic send_cmd(dvrt_pkg::cmd_t c, int a, int b, int cost);
		if (!no_idle && $urandom_range(99) < 17) begin
			in_valid <= 0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		in_valid <= 1;
		command <= c;
		node_a <= dvrt_pkg::NODE_W'(a);
		node_b <= dvrt_pkg::NODE_W'(b);
		edge_cost <= dvrt_pkg::COST_W'(cost);
		do @(posedge clk); while (!in_ready);
		apply_command(c, a, b, cost);
		if (c == dvrt_pkg::CMD_QUERY) queries_sent++;
		if (c == dvrt_pkg::CMD_RECOMPUTE) recomputes_sent++;
	endtask

	task automatic drain();
		in_valid <= 0;
		while (route_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// only called once drained; a trailing query guarantees recompute is done
	task automatic write_node_count(int v);
		int unsigned m;
		psel <= 1;
		pwrite <= 1;
		penable <= 0;
		paddr <= REG_NODE_COUNT;
		pwdata <= 32'(v);
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
		m = v & 31;
		active_nodes = (m < 1) ? 1 : (m > NN) ? NN : m;
		@(posedge clk);
	endtask

	always @(posedge clk) begin
		route_hop_t e;
		out_ready <= no_idle ? 1'b1 : ($urandom_range(99) >= 17);
		if (arst_n && out_valid && out_ready) begin
			hops_seen++;
			if (route_q.size() == 0) begin
				$display("%0t: unexpected result reach=%0d cost=%0d", $time, reachable,
					route_distance);
				errors++;
			end else begin
				e = route_q.pop_front();
				if (e.reach !== reachable) begin
					$display("%0t: reachable exp %0d got %0d", $time, e.reach, reachable);
					errors++;
				end
				if (e.cost_sum !== route_distance) begin
					$display("%0t: route_distance exp %0d got %0d", $time, e.cost_sum,
						route_distance);
					errors++;
				end
				if (e.hop !== next_hop) begin
					$display("%0t: next_hop exp %0d got %0d", $time, e.hop, next_hop);
					errors++;
				end
				if (e.node !== hop_node) begin
					$display("%0t: hop_node exp %0d got %0d", $time, e.node, hop_node);
					errors++;
				end
				if (e.last !== last_hop) begin
					$display("%0t: last_hop exp %0d got %0d", $time, e.last, last_hop);
					errors++;
				end
			end
		end
	end

	task automatic test_reset_state();
		// tables are empty before any recompute
		send_cmd(dvrt_pkg::CMD_QUERY, 0, 1, 0);
		send_cmd(dvrt_pkg::CMD_QUERY, 3, 3, 0);
		drain();
	endtask

	task automatic test_edits_and_specials();
		write_node_count(4);
		send_cmd(dvrt_pkg::CMD_SET, 0, 1, 16'hFFFF);
		send_cmd(dvrt_pkg::CMD_SET, 1, 2, 1);
		send_cmd(dvrt_pkg::CMD_SET, 0, 2, 16'hFFFF);
		send_cmd(dvrt_pkg::CMD_SET, 2, 3, 0);           // zero cost ignored
		send_cmd(dvrt_pkg::CMD_SET, 3, 3, 5);           // self link ignored
		send_cmd(dvrt_pkg::CMD_SET, 15, 2, 7);          // out of range ignored
		send_cmd(dvrt_pkg::CMD_REMOVE, 1, 3, 0);        // absent link
		send_cmd(dvrt_pkg::CMD_REMOVE, 12, 0, 0);
		send_cmd(dvrt_pkg::CMD_SET, 3, 1, 2);
		send_cmd(dvrt_pkg::CMD_SET, 3, 0, 16'hFFFE);    // direct 0->3 beats the path via 1
		send_cmd(dvrt_pkg::CMD_RECOMPUTE, 0, 0, 0);
		send_cmd(dvrt_pkg::CMD_QUERY, 0, 3, 0);
		send_cmd(dvrt_pkg::CMD_QUERY, 2, 0, 0);
		send_cmd(dvrt_pkg::CMD_QUERY, 1, 1, 0);
		send_cmd(dvrt_pkg::CMD_QUERY, 9, 0, 0);
		send_cmd(dvrt_pkg::CMD_REMOVE, 3, 1, 0);        // stale until recompute
		send_cmd(dvrt_pkg::CMD_QUERY, 0, 3, 0);
		drain();
		write_node_count(0);                            // clamps to one node
		send_cmd(dvrt_pkg::CMD_RECOMPUTE, 0, 0, 0);
		send_cmd(dvrt_pkg::CMD_QUERY, 0, 0, 0);
		send_cmd(dvrt_pkg::CMD_QUERY, 0, 1, 0);
		drain();
	endtask

	task automatic test_long_path();
		write_node_count(20);                           // clamps to max
		for (int i = 0; i < NN - 1; i++) send_cmd(dvrt_pkg::CMD_SET, i, i + 1, 1);
		send_cmd(dvrt_pkg::CMD_RECOMPUTE, 0, 0, 0);
		send_cmd(dvrt_pkg::CMD_QUERY, 0, 15, 0);
		send_cmd(dvrt_pkg::CMD_QUERY, 15, 0, 0);
		send_cmd(dvrt_pkg::CMD_QUERY, 5, 5, 0);
		drain();
		write_node_count(16);
		send_cmd(dvrt_pkg::CMD_QUERY, 15, 1, 0);
		drain();
	endtask

	task automatic random_phase(int n, int items);
		int r, a, b, cost;
		write_node_count(n);
		for (int i = 0; i < items; i++) begin
			no_idle = (i >= items / 2) && (n == 6);
			r = $urandom_range(99);
			if ($urandom_range(9) < 7) begin
				a = $urandom_range(n - 1);
				b = $urandom_range(n - 1);
			end else begin
				a = $urandom_range(15);
				b = $urandom_range(15);
			end
			cost = ($urandom_range(3) == 0) ? $urandom_range(16'hFFFF) : $urandom_range(4);
			if (r < 40) send_cmd(dvrt_pkg::CMD_SET, a, b, cost);
			else if (r < 52) send_cmd(dvrt_pkg::CMD_REMOVE, a, b, cost);
			else if (r < 62) send_cmd(dvrt_pkg::CMD_RECOMPUTE, a, b, cost);
			else send_cmd(dvrt_pkg::CMD_QUERY, a, b, cost);
		end
		send_cmd(dvrt_pkg::CMD_RECOMPUTE, 0, 0, 0);
		for (int i = 0; i < 4; i++)
			send_cmd(dvrt_pkg::CMD_QUERY, $urandom_range(n - 1), $urandom_range(n - 1), 0);
		no_idle = 0;
		drain();
	endtask

	initial begin
		for (int i = 0; i < NN*NN; i++) begin
			link_mem[i] = '0;
			dist_mem[i] = INF;
			parent_mem[i] = NO_PARENT;
		end
		active_nodes = 16;
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		test_reset_state();
		test_edits_and_specials();
		test_long_path();
		random_phase(5, 15);
		random_phase(6, 15);
		random_phase(3, 10);
		repeat (50) @(posedge clk);
		$display("Covered %0d queries, %0d recomputes, %0d route hops checked.",
			queries_sent, recomputes_sent, hops_seen);
		$display("Node counts 1 to 16, cost extremes, ties and long paths exercised.");
		if (errors == 0 && route_q.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
